// ----- rtl/sca_pkg.sv -----
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, constants and codes of the sample covariance accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  // vector size and derived widths
  localparam int ELEMENTS = 8;
  localparam int ROW_W    = $clog2(ELEMENTS);
  localparam int SMP_W    = 16;
  localparam int SUM_W    = 32;
  localparam int PSUM_W   = 48;
  localparam int DIV_W    = 64;
  localparam int CNT_W    = 16;
  localparam int DVS_W    = 16;
  localparam int DCNT_W   = $clog2(DIV_W);
  localparam int ROW_BITS = ELEMENTS * PSUM_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic signed [DIV_W-1:0] COV_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [DIV_W-1:0] COV_MIN = -64'sh0000_8000_0000_0000;

  // input action codes
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REPORT = 2'd2
  } sca_action_e;

  // report status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MEAN_ONLY = 2'd1,
    ST_EMPTY     = 2'd2
  } sca_status_e;

  // divider operand select
  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_Q1   = 2'd1,
    DIV_Q2   = 2'd2
  } sca_div_sel_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_ADD_END,
    S_ROW_RD,
    S_ROW_CAP,
    S_MEAN_WAIT,
    S_MUL,
    S_Q1_GO,
    S_Q1_WAIT,
    S_Q2_GO,
    S_Q2_WAIT,
    S_EMIT
  } sca_state_e;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [SMP_W-1:0] sample_0;
    logic signed [SMP_W-1:0] sample_1;
    logic signed [SMP_W-1:0] sample_2;
    logic signed [SMP_W-1:0] sample_3;
    logic signed [SMP_W-1:0] sample_4;
    logic signed [SMP_W-1:0] sample_5;
    logic signed [SMP_W-1:0] sample_6;
    logic signed [SMP_W-1:0] sample_7;
  } sca_in_item_t;

  typedef struct packed {
    logic [2:0]               row;
    logic [2:0]               col;
    logic signed [PSUM_W-1:0] covariance;
    logic signed [SMP_W-1:0]  row_mean;
    logic [1:0]               status;
    logic [CNT_W-1:0]         sample_count;
    logic                     count_saturated;
    logic                     last;
  } sca_out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic             clear;
    logic             add;
    logic             drop;
    logic             rd_en;
    logic             rd_add;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic             cap_row;
    logic             div_start;
    sca_div_sel_e     div_sel;
    logic             lat_mean;
    logic             lat_q1;
    logic             mul;
    logic             emit;
    logic             last;
  } sca_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_full;
    logic div_done;
    logic div_busy;
    logic out_free;
  } sca_sts_t;

endpackage

`default_nettype wire

// ----- rtl/sca_if.sv -----
// ----------------------------------------------------------------------------
// sca_in_if / sca_out_if
// Valid/ready stream channels of the covariance accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

interface sca_in_if;
  logic                  valid;
  logic                  ready;
  sca_pkg::sca_in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sca_out_if;
  logic                   valid;
  logic                   ready;
  sca_pkg::sca_out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/sca_ram.sv -----
// ----------------------------------------------------------------------------
// sca_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sca_div.sv -----
// ----------------------------------------------------------------------------
// sca_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [sca_pkg::DIV_W-1:0]    dividend_i,
  input  wire logic [sca_pkg::DVS_W-1:0]           divisor_i,
  output      logic                                busy_o,
  output      logic                                done_o,
  output      logic signed [sca_pkg::DIV_W-1:0]    quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [sca_pkg::DCNT_W-1:0]        cnt_q, cnt_d;
  logic [sca_pkg::DVS_W-1:0]         rem_q, rem_d;
  logic [sca_pkg::DIV_W-1:0]         quo_q, quo_d;
  logic [sca_pkg::DVS_W-1:0]         dvs_q, dvs_d;
  logic                              neg_q, neg_d;
  logic [sca_pkg::DVS_W:0]           rem_sh;
  logic [sca_pkg::DVS_W:0]           rem_sub;
  logic                              ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, quo_q[sca_pkg::DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[sca_pkg::DIV_W-1];
      quo_d  = dividend_i[sca_pkg::DIV_W-1] ? 64'(-dividend_i) : dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[sca_pkg::DVS_W-1:0] : rem_sh[sca_pkg::DVS_W-1:0];
      quo_d = {quo_q[sca_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

// ----- rtl/sca_datapath.sv -----
// ----------------------------------------------------------------------------
// sca_datapath
// Sums, product-sum row memory, multiplier lanes, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_datapath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sca_pkg::sca_in_item_t  in_data_i,
  input  wire sca_pkg::sca_cmd_t      cmd_i,
  output      sca_pkg::sca_sts_t      sts_o,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      sca_pkg::sca_out_item_t out_data_o
);

  localparam int E = sca_pkg::ELEMENTS;
  localparam int PW = sca_pkg::PSUM_W;

  logic signed [sca_pkg::SMP_W-1:0]  in_smp [8];
  logic signed [sca_pkg::SMP_W-1:0]  smp_q [E];
  logic signed [sca_pkg::SUM_W-1:0]  esum_q [E];
  logic [sca_pkg::CNT_W-1:0]         count_q;
  logic                              dropped_q;
  logic [E-1:0]                      row_vld_q;
  logic signed [2*sca_pkg::SMP_W-1:0] prod_q [E];
  logic                              add_pend_q;
  logic                              rd_vld_q;
  logic [sca_pkg::ROW_W-1:0]         rd_row_q;
  logic [sca_pkg::ROW_BITS-1:0]      rd_data;
  logic [sca_pkg::ROW_BITS-1:0]      wr_data;
  logic signed [PW-1:0]              row_buf_q [E];
  logic signed [sca_pkg::DIV_W-1:0]  tprod_q;
  logic signed [sca_pkg::DIV_W-1:0]  q1_q;
  logic signed [sca_pkg::SMP_W-1:0]  mean_q;
  logic signed [sca_pkg::DIV_W-1:0]  div_dividend;
  logic [sca_pkg::DVS_W-1:0]         div_divisor;
  logic                              div_busy;
  logic                              div_done;
  logic signed [sca_pkg::DIV_W-1:0]  div_quo;
  logic signed [sca_pkg::DIV_W-1:0]  cov_sat;
  logic signed [PW-1:0]              p_sel;
  sca_pkg::sca_status_e              status;
  logic                              out_valid_q;
  sca_pkg::sca_out_item_t            out_q;
  logic                              out_free;

  assign in_smp[0] = in_data_i.sample_0;
  assign in_smp[1] = in_data_i.sample_1;
  assign in_smp[2] = in_data_i.sample_2;
  assign in_smp[3] = in_data_i.sample_3;
  assign in_smp[4] = in_data_i.sample_4;
  assign in_smp[5] = in_data_i.sample_5;
  assign in_smp[6] = in_data_i.sample_6;
  assign in_smp[7] = in_data_i.sample_7;

  // status of the sample count
  always_comb begin
    case (count_q)
      '0:               status = sca_pkg::ST_EMPTY;
      sca_pkg::CNT_W'(1): status = sca_pkg::ST_MEAN_ONLY;
      default:          status = sca_pkg::ST_OK;
    endcase
  end

  // count, drop flag and element sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      for (int i = 0; i < E; i++) begin
        esum_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      for (int i = 0; i < E; i++) begin
        esum_q[i] <= '0;
      end
    end else if (cmd_i.drop) begin
      dropped_q <= 1'b1;
    end else if (cmd_i.add) begin
      count_q <= count_q + 1'b1;
      for (int i = 0; i < E; i++) begin
        esum_q[i] <= esum_q[i] + sca_pkg::SUM_W'(in_smp[i]);
      end
    end
  end

  // latch the sample for the row updates
  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      for (int i = 0; i < E; i++) begin
        smp_q[i] <= in_smp[i];
      end
    end
  end

  // multiplier lanes for one row of the product sums
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < E; b++) begin
      prod_q[b] <= smp_q[cmd_i.row] * smp_q[b];
    end
  end

  // read tracking and row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_pend_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_row_q   <= '0;
      row_vld_q  <= '0;
    end else begin
      add_pend_q <= cmd_i.rd_en && cmd_i.rd_add;
      if (cmd_i.rd_en) begin
        rd_vld_q <= row_vld_q[cmd_i.row];
        rd_row_q <= cmd_i.row;
      end
      if (cmd_i.clear) begin
        row_vld_q <= '0;
      end else if (add_pend_q) begin
        row_vld_q[rd_row_q] <= 1'b1;
      end
    end
  end

  // product sum accumulate
  always_comb begin
    for (int b = 0; b < E; b++) begin
      wr_data[b*PW +: PW] = (rd_vld_q ? rd_data[b*PW +: PW] : '0) + PW'(prod_q[b]);
    end
  end

  sca_ram #(
    .WIDTH (sca_pkg::ROW_BITS),
    .DEPTH (E)
  ) u_psum_ram (
    .clk_i     (clk_i),
    .wr_en_i   (add_pend_q),
    .wr_addr_i (rd_row_q),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (cmd_i.row),
    .rd_data_o (rd_data)
  );

  // report operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_row) begin
      for (int b = 0; b < E; b++) begin
        row_buf_q[b] <= rd_vld_q ? rd_data[b*PW +: PW] : '0;
      end
    end
    if (cmd_i.mul) begin
      tprod_q <= esum_q[cmd_i.row] * esum_q[cmd_i.col];
    end
    if (cmd_i.lat_q1) begin
      q1_q <= div_quo;
    end
    if (cmd_i.lat_mean) begin
      mean_q <= (status == sca_pkg::ST_EMPTY) ? '0 : div_quo[sca_pkg::SMP_W-1:0];
    end
  end

  assign p_sel = row_buf_q[cmd_i.col];

  // divider operand select
  always_comb begin
    case (cmd_i.div_sel)
      sca_pkg::DIV_MEAN: begin
        div_dividend = sca_pkg::DIV_W'(esum_q[cmd_i.row]);
        div_divisor  = count_q;
      end
      sca_pkg::DIV_Q1: begin
        div_dividend = tprod_q;
        div_divisor  = count_q;
      end
      default: begin
        div_dividend = sca_pkg::DIV_W'(p_sel) - q1_q;
        div_divisor  = count_q - 1'b1;
      end
    endcase
  end

  sca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // saturate to 48 bits
  always_comb begin
    if (div_quo > sca_pkg::COV_MAX) begin
      cov_sat = sca_pkg::COV_MAX;
    end else if (div_quo < sca_pkg::COV_MIN) begin
      cov_sat = sca_pkg::COV_MIN;
    end else begin
      cov_sat = div_quo;
    end
  end

  // result register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.row             <= 3'(cmd_i.row);
      out_q.col             <= 3'(cmd_i.col);
      out_q.covariance      <= (status == sca_pkg::ST_OK) ? cov_sat[PW-1:0] : '0;
      out_q.row_mean        <= mean_q;
      out_q.status          <= status;
      out_q.sample_count    <= count_q;
      out_q.count_saturated <= dropped_q;
      out_q.last            <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.count_full = (count_q == sca_pkg::COUNT_MAX);
  assign sts_o.div_done   = div_done;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.out_free   = out_free;

  // checks
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free) else $error("result register overwritten");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy) else $error("divider restarted while busy");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (count_q == '0) && (row_vld_q == '0) && !dropped_q)
    else $error("clear left state behind");
  a_row_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_pend_q && !cmd_i.clear |=> row_vld_q[$past(rd_row_q)])
    else $error("written row not marked valid");

endmodule

`default_nettype wire

// ----- rtl/sca_ctrl.sv -----
// ----------------------------------------------------------------------------
// sca_ctrl
// Sequencer for clear, add and report actions of the covariance accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_action_i,
  output      logic              in_ready_o,
  input  wire sca_pkg::sca_sts_t sts_i,
  output      sca_pkg::sca_cmd_t cmd_o
);

  localparam logic [sca_pkg::ROW_W-1:0] LAST_IDX = sca_pkg::ROW_W'(sca_pkg::ELEMENTS - 1);

  sca_pkg::sca_state_e       state_q, state_d;
  logic [sca_pkg::ROW_W-1:0] row_q, row_d;
  logic [sca_pkg::ROW_W-1:0] col_q, col_d;
  logic                      accept;

  assign in_ready_o = (state_q == sca_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    case (state_q)
      sca_pkg::S_IDLE: begin
        row_d = '0;
        col_d = '0;
        if (accept) begin
          case (in_action_i)
            sca_pkg::ACT_ADD:    if (!sts_i.count_full) state_d = sca_pkg::S_ADD;
            sca_pkg::ACT_REPORT: state_d = sca_pkg::S_ROW_RD;
            default:             state_d = sca_pkg::S_IDLE;
          endcase
        end
      end
      sca_pkg::S_ADD: begin
        if (row_q == LAST_IDX) begin
          state_d = sca_pkg::S_ADD_END;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      sca_pkg::S_ADD_END: state_d = sca_pkg::S_IDLE;
      sca_pkg::S_ROW_RD:  state_d = sca_pkg::S_ROW_CAP;
      sca_pkg::S_ROW_CAP: state_d = sca_pkg::S_MEAN_WAIT;
      sca_pkg::S_MEAN_WAIT: begin
        if (sts_i.div_done) begin
          state_d = sca_pkg::S_MUL;
          col_d   = '0;
        end
      end
      sca_pkg::S_MUL:   state_d = sca_pkg::S_Q1_GO;
      sca_pkg::S_Q1_GO: state_d = sca_pkg::S_Q1_WAIT;
      sca_pkg::S_Q1_WAIT: if (sts_i.div_done) state_d = sca_pkg::S_Q2_GO;
      sca_pkg::S_Q2_GO: state_d = sca_pkg::S_Q2_WAIT;
      sca_pkg::S_Q2_WAIT: if (sts_i.div_done) state_d = sca_pkg::S_EMIT;
      sca_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          if (col_q != LAST_IDX) begin
            col_d   = col_q + 1'b1;
            state_d = sca_pkg::S_MUL;
          end else if (row_q != LAST_IDX) begin
            row_d   = row_q + 1'b1;
            state_d = sca_pkg::S_ROW_RD;
          end else begin
            state_d = sca_pkg::S_IDLE;
          end
        end
      end
      default: state_d = sca_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.row     = row_q;
    cmd_o.col     = col_q;
    cmd_o.div_sel = sca_pkg::DIV_MEAN;
    case (state_q)
      sca_pkg::S_IDLE: begin
        if (accept) begin
          case (in_action_i)
            sca_pkg::ACT_CLEAR: cmd_o.clear = 1'b1;
            sca_pkg::ACT_ADD: begin
              cmd_o.drop = sts_i.count_full;
              cmd_o.add  = !sts_i.count_full;
            end
            default: cmd_o.clear = 1'b0;
          endcase
        end
      end
      sca_pkg::S_ADD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_add = 1'b1;
      end
      sca_pkg::S_ROW_RD: cmd_o.rd_en = 1'b1;
      sca_pkg::S_ROW_CAP: begin
        cmd_o.cap_row   = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      sca_pkg::S_MEAN_WAIT: cmd_o.lat_mean = sts_i.div_done;
      sca_pkg::S_MUL:       cmd_o.mul = 1'b1;
      sca_pkg::S_Q1_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = sca_pkg::DIV_Q1;
      end
      sca_pkg::S_Q1_WAIT: cmd_o.lat_q1 = sts_i.div_done;
      sca_pkg::S_Q2_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = sca_pkg::DIV_Q2;
      end
      sca_pkg::S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.last = (row_q == LAST_IDX) && (col_q == LAST_IDX);
      end
      default: cmd_o.mul = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sca_pkg::S_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sample_covariance_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// sample_covariance_accumulator_top
// Sample covariance accumulator with row-by-row covariance report.
// ----------------------------------------------------------------------------
// One item is taken at a time. For an add, the product sums live in a
// row-wide RAM and eight multiplier lanes update one row per cycle. A report
// reads each row once, then works out the row mean and then each covariance
// entry of that row with the shared one-bit-per-cycle 64-bit divider, which
// runs twice per entry; a stalled output holds the report back. Results come
// out row by row, last flags the final entry.
`default_nettype none

module sample_covariance_accumulator_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sca_in_if.sink    in_i,
  sca_out_if.source out_o
);

  sca_pkg::sca_cmd_t cmd;
  sca_pkg::sca_sts_t sts;

  sca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.data.action),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sca_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

`default_nettype wire
